### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. Define NO_ASSERTIONS
// to compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_HOLDS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define AST_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define AST_HOLDS(label, clk, rstn, prop, msg)

`define AST_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

### rtl/crfp_pkg.sv
// ---------------------------------------------------------------------------
// crfp_pkg
// Types, constants and helpers shared by the camera ray generator.
// ---------------------------------------------------------------------------
package crfp_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z    = 8'd5;

    localparam logic [30:0] RST_SPAN_X   = 31'd16777216;
    localparam logic [30:0] RST_SPAN_Y   = 31'd16777216;
    localparam logic [30:0] RST_PIX_STEP = 31'd16384;
    localparam logic [59:0] RST_ROT_X    = 60'd262144;
    localparam logic [59:0] RST_ROT_Y    = 60'd274877906944;
    localparam logic [59:0] RST_ROT_Z    = 60'd288230376151711744;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } crfp_in_t;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } crfp_out_t;

    typedef struct packed {
        logic [30:0] span_x;
        logic [30:0] span_y;
        logic [30:0] pix_step;
        logic [59:0] rot_x;
        logic [59:0] rot_y;
        logic [59:0] rot_z;
    } crfp_cfg_t;

    // rotated components, sign and magnitude
    typedef struct packed {
        logic [2:0][60:0] mag;
        logic [2:0]       neg;
    } crfp_rot_t;

    // normalised components
    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } crfp_vec_t;

    // quotients before sign
    typedef struct packed {
        logic [2:0][30:0] q;
        logic [2:0]       neg;
        logic             zero;
    } crfp_quo_t;

    function automatic logic signed [19:0] rot_entry(input logic [59:0] row, input int j);
        return $signed(row[20*j +: 20]);
    endfunction

endpackage

### rtl/crfp_world.sv
// ---------------------------------------------------------------------------
// crfp_world
// Pixel centre to canvas point, saturation and rotation. Four stages.
// ---------------------------------------------------------------------------
module crfp_world
    import crfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  crfp_cfg_t cfg,
    input  logic      in_valid,
    input  crfp_in_t  in_data,
    output logic      out_valid,
    output crfp_rot_t out_data
);

    localparam int PROD_W = COORD_BITS + 1 + 31;
    localparam int DW     = PROD_W + 1;
    localparam logic signed [DW-1:0] W_HI = DW'((64'sd1 <<< 39) - 64'sd1);
    localparam logic signed [DW-1:0] W_LO = ~W_HI;

    logic [3:0] valid_reg;

    // stage 1
    logic [PROD_W-1:0] prodx_reg, prody_reg;
    logic [PROD_W-1:0] prodx_next, prody_next;

    // stage 2
    logic signed [39:0] wx_reg, wy_reg;
    logic signed [39:0] wx_next, wy_next;
    logic signed [DW-1:0] dx, dy;

    // stage 3
    logic signed [59:0] prod_reg [3][2];
    logic signed [59:0] prod_next [3][2];
    logic [59:0] rows [3];

    // stage 4
    crfp_rot_t rot_reg, rot_next;

    assign rows[0] = cfg.rot_x;
    assign rows[1] = cfg.rot_y;
    assign rows[2] = cfg.rot_z;

    always_comb begin
        prodx_next = PROD_W'({in_data.pixel_x[COORD_BITS-1:0], 1'b1}) * PROD_W'(cfg.pix_step);
        prody_next = PROD_W'({in_data.pixel_y[COORD_BITS-1:0], 1'b1}) * PROD_W'(cfg.pix_step);
    end

    always_comb begin
        dx = $signed(DW'({cfg.span_x, 1'b0})) - $signed(DW'(prodx_reg));
        dy = $signed(DW'({cfg.span_y, 1'b0})) - $signed(DW'(prody_reg));
        if (dx > W_HI) begin
            wx_next = 40'(W_HI);
        end else if (dx < W_LO) begin
            wx_next = 40'(W_LO);
        end else begin
            wx_next = 40'(dx);
        end
        if (dy > W_HI) begin
            wy_next = 40'(W_HI);
        end else if (dy < W_LO) begin
            wy_next = 40'(W_LO);
        end else begin
            wy_next = 40'(dy);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i][0] = 60'(rot_entry(rows[i], 0)) * 60'(wx_reg);
            prod_next[i][1] = 60'(rot_entry(rows[i], 1)) * 60'(wy_reg);
        end
    end

    // z of the canvas point is -1.0 in Q.25
    always_comb begin
        logic signed [61:0] v;
        for (int i = 0; i < 3; i++) begin
            v = 62'(prod_reg[i][0]) + 62'(prod_reg[i][1])
                - (62'(rot_entry(rows[i], 2)) <<< 25);
            rot_next.neg[i] = v[61];
            rot_next.mag[i] = 61'(v[61] ? -v : v);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
            wx_reg    <= wx_next;
            wy_reg    <= wy_next;
            prod_reg  <= prod_next;
            rot_reg   <= rot_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = rot_reg;

endmodule

### rtl/crfp_norm.sv
// ---------------------------------------------------------------------------
// crfp_norm
// Common normalising shift in two steps, squares and their sum.
// ---------------------------------------------------------------------------
module crfp_norm
    import crfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  crfp_rot_t   in_data,
    output logic        out_valid,
    output crfp_vec_t   out_vec,
    output logic [63:0] out_sum
);

    logic [3:0] valid_reg;

    // stage 5: byte-wise coarse shift
    logic [2:0][63:0] sh_reg, sh_next;
    logic [2:0]       neg5_reg;
    logic             zero5_reg, zero5_next;
    logic [63:0]      or_all;
    logic [2:0]       hb;

    // stage 6: fine shift
    crfp_vec_t   vec6_reg, vec6_next;
    logic [7:0]  top;
    logic [2:0]  fs;
    logic [63:0] tmp;

    // stage 7 / 8
    crfp_vec_t        vec7_reg, vec8_reg;
    logic [2:0][61:0] sq_reg, sq_next;
    logic [63:0]      sum_reg, sum_next;

    always_comb begin
        or_all = 64'(in_data.mag[0] | in_data.mag[1] | in_data.mag[2]);
        hb = '0;
        for (int g = 0; g < 8; g++) begin
            if (or_all[8*g +: 8] != 8'd0) begin
                hb = 3'(g);
            end
        end
        zero5_next = (or_all == 64'd0);
        for (int i = 0; i < 3; i++) begin
            sh_next[i] = 64'(in_data.mag[i]) << {3'd7 - hb, 3'b000};
        end
    end

    always_comb begin
        top = sh_reg[0][63:56] | sh_reg[1][63:56] | sh_reg[2][63:56];
        fs = '0;
        for (int b = 0; b < 8; b++) begin
            if (top[b]) begin
                fs = 3'(7 - b);
            end
        end
        tmp = '0;
        for (int i = 0; i < 3; i++) begin
            tmp = sh_reg[i] << fs;
            vec6_next.mag[i] = tmp[63:33];
        end
        vec6_next.neg  = neg5_reg;
        vec6_next.zero = zero5_reg;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = 62'(vec6_reg.mag[i]) * 62'(vec6_reg.mag[i]);
        end
        sum_next = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_reg    <= sh_next;
            neg5_reg  <= in_data.neg;
            zero5_reg <= zero5_next;
            vec6_reg  <= vec6_next;
            sq_reg    <= sq_next;
            vec7_reg  <= vec6_reg;
            sum_reg   <= sum_next;
            vec8_reg  <= vec7_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_vec   = vec8_reg;
    assign out_sum   = sum_reg;

endmodule

### rtl/crfp_isqrt.sv
// ---------------------------------------------------------------------------
// crfp_isqrt
// Integer square root of the squared length, one root bit per stage.
// ---------------------------------------------------------------------------
module crfp_isqrt
    import crfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  crfp_vec_t   in_vec,
    input  logic [63:0] in_sum,
    output logic        out_valid,
    output crfp_vec_t   out_vec,
    output logic [31:0] out_len
);

    localparam int STEPS = 32;

    logic        valid_reg [STEPS];
    logic [63:0] rem_reg   [STEPS];
    logic [31:0] root_reg  [STEPS];
    crfp_vec_t   vec_reg   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = STEPS - 1 - k;

        logic        valid_in;
        logic [63:0] rem_in;
        logic [31:0] root_in;
        crfp_vec_t   vec_in;
        logic [65:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_sum;
            assign root_in  = '0;
            assign vec_in   = in_vec;
        end else begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign vec_in   = vec_reg[k-1];
        end

        assign trial = (66'(root_in) << (B + 1)) | (66'd1 << (2 * B));
        assign take  = (66'(rem_in) >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? rem_in - trial[63:0] : rem_in;
                root_reg[k] <= take ? root_in | (32'd1 << B) : root_in;
                vec_reg[k]  <= vec_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_vec   = vec_reg[STEPS-1];
    assign out_len   = root_reg[STEPS-1];

endmodule

### rtl/crfp_div.sv
// ---------------------------------------------------------------------------
// crfp_div
// Rounded division of each component by the length, three restoring
// dividers side by side, one quotient bit per stage.
// ---------------------------------------------------------------------------
module crfp_div
    import crfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  crfp_vec_t   in_vec,
    input  logic [31:0] in_len,
    output logic        out_valid,
    output crfp_quo_t   out_quo
);

    localparam int STEPS = 31;

    typedef struct packed {
        logic [2:0][61:0] rem;
        logic [2:0][30:0] q;
        logic [31:0]      len;
        logic [2:0]       neg;
        logic             zero;
    } crfp_div_t;

    logic      valid_reg [STEPS+1];
    crfp_div_t st_reg    [STEPS+1];
    crfp_div_t prep_next;

    // numerator with half the divisor added for rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prep_next.rem[i] = (62'(in_vec.mag[i]) << 30) + 62'(in_len >> 1);
        end
        prep_next.q    = '0;
        prep_next.len  = in_len;
        prep_next.neg  = in_vec.neg;
        prep_next.zero = in_vec.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= prep_next;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = STEPS - 1 - k;

        crfp_div_t   nxt;
        logic [61:0] dsh;

        assign dsh = 62'(st_reg[k].len) << B;

        always_comb begin
            nxt = st_reg[k];
            for (int i = 0; i < 3; i++) begin
                if (st_reg[k].rem[i] >= dsh) begin
                    nxt.rem[i] = st_reg[k].rem[i] - dsh;
                    nxt.q[i]   = st_reg[k].q[i] | (31'd1 << B);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= nxt;
            end
        end
    end

    assign out_valid    = valid_reg[STEPS];
    assign out_quo.q    = st_reg[STEPS].q;
    assign out_quo.neg  = st_reg[STEPS].neg;
    assign out_quo.zero = st_reg[STEPS].zero;

endmodule

### rtl/camera_ray_for_pixel_core.sv
// ---------------------------------------------------------------------------
// camera_ray_for_pixel_core
// Path: a request passes the world, norm, square-root and divider stages and the output register to m_valid.
// Throughput: one pixel per cycle; the whole pipeline holds while the
// output register is full and m_ready is low.
// Reset: aresetn clears all valid bits and loads the default camera set-up.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_ray_for_pixel_core
    import crfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  crfp_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output crfp_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    crfp_cfg_t cfg_reg;
    logic      en;

    logic      world_valid;
    crfp_rot_t world_data;

    logic        norm_valid;
    crfp_vec_t   norm_vec;
    logic [63:0] norm_sum;

    logic        sqrt_valid;
    crfp_vec_t   sqrt_vec;
    logic [31:0] sqrt_len;

    logic      div_valid;
    crfp_quo_t div_quo;

    logic      m_valid_reg;
    crfp_out_t m_data_reg, m_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.span_x   <= RST_SPAN_X;
            cfg_reg.span_y   <= RST_SPAN_Y;
            cfg_reg.pix_step <= RST_PIX_STEP;
            cfg_reg.rot_x    <= RST_ROT_X;
            cfg_reg.rot_y    <= RST_ROT_Y;
            cfg_reg.rot_z    <= RST_ROT_Z;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPAN_X:   cfg_reg.span_x   <= cfg_data[30:0];
                CFG_SPAN_Y:   cfg_reg.span_y   <= cfg_data[30:0];
                CFG_PIX_STEP: cfg_reg.pix_step <= cfg_data[30:0];
                CFG_ROT_X:    cfg_reg.rot_x    <= cfg_data[59:0];
                CFG_ROT_Y:    cfg_reg.rot_y    <= cfg_data[59:0];
                CFG_ROT_Z:    cfg_reg.rot_z    <= cfg_data[59:0];
                default: begin
                end
            endcase
        end
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    crfp_world u_world (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (world_valid),
        .out_data  (world_data)
    );

    crfp_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (world_valid),
        .in_data   (world_data),
        .out_valid (norm_valid),
        .out_vec   (norm_vec),
        .out_sum   (norm_sum)
    );

    crfp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (norm_valid),
        .in_vec    (norm_vec),
        .in_sum    (norm_sum),
        .out_valid (sqrt_valid),
        .out_vec   (sqrt_vec),
        .out_len   (sqrt_len)
    );

    crfp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_vec    (sqrt_vec),
        .in_len    (sqrt_len),
        .out_valid (div_valid),
        .out_quo   (div_quo)
    );

    // zero direction gives a zero result
    always_comb begin
        if (div_quo.zero) begin
            m_data_next = '0;
        end else begin
            m_data_next.dir_x = div_quo.neg[0] ? -32'(div_quo.q[0]) : 32'(div_quo.q[0]);
            m_data_next.dir_y = div_quo.neg[1] ? -32'(div_quo.q[1]) : 32'(div_quo.q[1]);
            m_data_next.dir_z = div_quo.neg[2] ? -32'(div_quo.q[2]) : 32'(div_quo.q[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `AST_HOLDS(a_len_range, aclk, aresetn, (sqrt_valid && !sqrt_vec.zero) |-> (sqrt_len[31:30] != 2'b00), "normalised length below one")
    `AST_NEVER(a_quo_unit, aclk, aresetn, div_valid && !div_quo.zero && (div_quo.q[0] > 31'h4000_0000 || div_quo.q[1] > 31'h4000_0000 || div_quo.q[2] > 31'h4000_0000), "component above one")
    `AST_NEVER(a_out_min, aclk, aresetn, m_valid && (m_data.dir_x == 32'sh8000_0000 || m_data.dir_y == 32'sh8000_0000 || m_data.dir_z == 32'sh8000_0000), "most negative code on output")

endmodule

### bench/tb_camera_ray_for_pixel_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_camera_ray_for_pixel_core
// Self-checking bench for the camera ray generator. Pixel requests are fed
// through a queue-driven driver, each accepted request is predicted in the
// bench and compared against the ray direction returned by the block, over
// several camera set-ups and handshake idling phases.
// ----------------------------------------------------------------------------
module tb_camera_ray_for_pixel_core;
    import crfp_pkg::*;

    localparam int LATENCY = 73;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    crfp_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    crfp_out_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    camera_ray_for_pixel_core dut (.*);

    // bench copy of the camera set-up
    logic [30:0] cam_half_w, cam_half_h, cam_pix;
    logic [59:0] cam_rot [3];

    crfp_in_t  pixel_queue [$];
    crfp_out_t ray_queue [$];
    logic      s_taken;
    int        send_idle_pct, recv_stall_pct, hold_cycles;
    int        mismatches;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [63:0] world_point(logic [30:0] half, logic [11:0] p);
        logic signed [63:0] w;
        w = $signed({33'd0, half} <<< 1)
            - $signed(64'(2 * {52'd0, p} + 1) * {33'd0, cam_pix});
        if (w > 64'sd549755813887) w = 64'sd549755813887;
        if (w < -64'sd549755813888) w = -64'sd549755813888;
        return w;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic crfp_out_t ray_direction(crfp_in_t px);
        logic signed [63:0] pt [3];
        logic signed [63:0] v;
        logic signed [19:0] e;
        logic [63:0] mag [3];
        logic [63:0] maxm, sum, len, q;
        logic        neg [3];
        logic signed [31:0] d [3];
        int          msb;
        crfp_out_t   r;
        pt[0] = world_point(cam_half_w, px.pixel_x);
        pt[1] = world_point(cam_half_h, px.pixel_y);
        pt[2] = -(64'sd1 <<< 25);
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            v = 0;
            for (int j = 0; j < 3; j++) begin
                e = cam_rot[i][20*j +: 20];
                v += 64'(e) * pt[j];
            end
            neg[i] = v < 0;
            mag[i] = neg[i] ? -v : v;
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) return '0;
        msb = 0;
        while (maxm > 1) begin
            maxm = maxm >> 1;
            msb++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (msb > 30) ? mag[i] >> (msb - 30) : mag[i] << (30 - msb);
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 64'd1073741824 + (len >> 1)) / len;
            if (q > 64'd2147483647) q = 64'd2147483647;
            d[i] = neg[i] ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
        r.dir_x = d[0];
        r.dir_y = d[1];
        r.dir_z = d[2];
        return r;
    endfunction

    // request acceptance at the rising edge
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) ray_queue.push_back(ray_direction(s_data));
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pixel_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge aclk) begin
        crfp_out_t exp_ray;
        if (aresetn && m_valid && m_ready) begin
            if (ray_queue.size() == 0) begin
                $error("unexpected ray %h", m_data);
                mismatches++;
            end else begin
                exp_ray = ray_queue.pop_front();
                if (m_data.dir_x !== exp_ray.dir_x) begin
                    $error("dir_x exp %0d got %0d", exp_ray.dir_x, m_data.dir_x);
                    mismatches++;
                end
                if (m_data.dir_y !== exp_ray.dir_y) begin
                    $error("dir_y exp %0d got %0d", exp_ray.dir_y, m_data.dir_y);
                    mismatches++;
                end
                if (m_data.dir_z !== exp_ray.dir_z) begin
                    $error("dir_z exp %0d got %0d", exp_ray.dir_z, m_data.dir_z);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SPAN_X:   cam_half_w = val[30:0];
            CFG_SPAN_Y:   cam_half_h = val[30:0];
            CFG_PIX_STEP: cam_pix    = val[30:0];
            CFG_ROT_X:    cam_rot[0] = val[59:0];
            CFG_ROT_Y:    cam_rot[1] = val[59:0];
            CFG_ROT_Z:    cam_rot[2] = val[59:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pixel_queue.size() > 0 || s_valid || ray_queue.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [59:0] rand_row();
        logic [59:0] r;
        for (int j = 0; j < 3; j++) r[20*j +: 20] = 20'($urandom_range(20'hFFFFF));
        return r;
    endfunction

    function automatic crfp_in_t rand_pixel();
        crfp_in_t p;
        p.pixel_x = 12'($urandom_range(4095));
        p.pixel_y = 12'($urandom_range(4095));
        return p;
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) pixel_queue.push_back(rand_pixel());
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_taken = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        mismatches = 0;
        cam_half_w = RST_SPAN_X;
        cam_half_h = RST_SPAN_Y;
        cam_pix = RST_PIX_STEP;
        cam_rot[0] = RST_ROT_X;
        cam_rot[1] = RST_ROT_Y;
        cam_rot[2] = RST_ROT_Z;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: corners and interior pixels under the reset set-up
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd4095, 12'd4095});
        pixel_queue.push_back('{12'd0, 12'd4095});
        pixel_queue.push_back('{12'd4095, 12'd0});
        pixel_queue.push_back('{12'd1023, 12'd1023});
        pixel_queue.push_back('{12'd2048, 12'd1024});
        pixel_queue.push_back('{12'hAAA, 12'h555});
        pixel_queue.push_back('{12'h555, 12'hAAA});
        drain();

        // far canvas points hit the clamp
        write_reg(CFG_SPAN_X, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPAN_Y, 64'h7FFF_FFFF);
        write_reg(CFG_PIX_STEP, 64'h7FFF_FFFF);
        write_reg(CFG_ROT_X, 64'hF000_0000_0004_0000);
        write_reg(8'd6, 64'h1234);
        write_reg(8'd255, 64'hFFFF);
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd4095, 12'd4095});
        pixel_queue.push_back('{12'd0, 12'd4095});
        pixel_queue.push_back('{12'd2000, 12'd7});
        drain();

        // zero rotation gives the zero vector
        write_reg(CFG_ROT_X, 64'd0);
        write_reg(CFG_ROT_Y, 64'd0);
        write_reg(CFG_ROT_Z, 64'd0);
        write_reg(CFG_SPAN_X, 64'd0);
        write_reg(CFG_SPAN_Y, 64'd0);
        write_reg(CFG_PIX_STEP, 64'd0);
        pixel_queue.push_back('{12'd5, 12'd9});
        pixel_queue.push_back('{12'd4095, 12'd0});
        drain();

        // extreme rotation entries
        write_reg(CFG_ROT_X, {4'hF, 20'h80000, 20'h80000, 20'h80000});
        write_reg(CFG_ROT_Y, {4'h0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        write_reg(CFG_ROT_Z, {4'h0, 20'h80000, 20'h7FFFF, 20'h00001});
        write_reg(CFG_SPAN_X, 64'h0100_0000);
        write_reg(CFG_SPAN_Y, 64'h0080_0000);
        write_reg(CFG_PIX_STEP, 64'd1);
        pixel_queue.push_back('{12'd0, 12'd0});
        pixel_queue.push_back('{12'd4095, 12'd4095});
        pixel_queue.push_back('{12'd1, 12'd4094});
        drain();

        // random set-ups across idling phases
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_SPAN_X, {$urandom, $urandom} >> $urandom_range(63, 33));
            write_reg(CFG_SPAN_Y, {$urandom, $urandom} >> $urandom_range(63, 33));
            write_reg(CFG_PIX_STEP, {$urandom, $urandom} >> $urandom_range(63, 33));
            write_reg(CFG_ROT_X, {4'($urandom), rand_row()});
            write_reg(CFG_ROT_Y, {4'($urandom), rand_row()});
            write_reg(CFG_ROT_Z, {4'($urandom), rand_row()});
            case (ph % 4)
                0: run_phase(125, 0, 0);
                1: run_phase(125, 67, 0);
                2: run_phase(125, 0, 67);
                default: run_phase(125, 20, 20);
            endcase
        end

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        repeat (200) pixel_queue.push_back(rand_pixel());
        drain();

        if (mismatches == 0) begin
            $display("PASS camera_ray_for_pixel_core");
        end else begin
            $display("FAIL camera_ray_for_pixel_core");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL camera_ray_for_pixel_core");
        $finish;
    end

endmodule
